[design/sfr_pkg.sv]
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

  localparam int CFG_WIDTH         = 64;
  localparam int CMD_BYTES         = CFG_WIDTH / 8;
  localparam int MAX_PATTERN_DFLT  = 8;
  localparam int MAX_REPLACEMENT   = 8;
  localparam int QUEUE_DEPTH_DFLT  = 2;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } sfr_reg_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } sfr_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } sfr_out_t;

  // One burst of output bytes produced by one input beat.
  typedef struct packed {
    logic [CMD_BYTES-1:0][7:0] bytes;
    logic [3:0]                count;
    logic                      last;
  } sfr_cmd_t;

  typedef struct packed {
    logic     valid;
    sfr_cmd_t cmd;
  } sfr_push_t;

endpackage

[design/sfr_front.sv]
// Front end: config registers, match window and per-beat classification.
module sfr_front
  import sfr_pkg::*;
#(
  parameter int MaxPattern = MAX_PATTERN_DFLT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [CFG_WIDTH-1:0] cfg_data_i,
  input  logic                 accept_i,
  input  sfr_in_t              in_data_i,
  output sfr_push_t            push_o
);

  localparam int W = MaxPattern;

  logic [CFG_WIDTH-1:0] pat_q, rep_q;
  logic [3:0]           plen_q, rlen_q;
  logic [3:0]           fill_q, fill_d;
  logic [W-1:0][7:0]    win_q, win_sh;

  logic [3:0]        plen, rlen, n, shift;
  logic [W-1:0][7:0] cur;
  logic [W:0]        ok;
  logic              full_match;
  sfr_cmd_t          cmd;

  always_comb begin
    if (plen_q == 4'd0) plen = 4'd1;
    else if (plen_q > 4'(W)) plen = 4'(W);
    else plen = plen_q;
    if (rlen_q == 4'd0) rlen = 4'd1;
    else if (rlen_q > 4'(MAX_REPLACEMENT)) rlen = 4'(MAX_REPLACEMENT);
    else rlen = rlen_q;
  end

  // Pending bytes plus the new one, oldest first.
  always_comb begin
    n = fill_q + 4'd1;
    for (int k = 0; k < W; k++) begin
      if (4'(k) < fill_q) cur[k] = win_q[k];
      else if (4'(k) == fill_q) cur[k] = in_data_i.in_byte;
      else cur[k] = 8'h00;
    end
  end

  // ok[s]: bytes from position s onward form a prefix of the pattern.
  always_comb begin
    full_match = (n == plen);
    for (int k = 0; k < W; k++) begin
      if (4'(k) < n && cur[k] != pat_q[8*k +: 8]) full_match = 1'b0;
    end
    for (int s = 0; s <= W; s++) begin
      ok[s] = 1'b1;
      for (int k = 0; k < W - s; k++) begin
        if (4'(s + k) < n && cur[s + k] != pat_q[8*k +: 8]) ok[s] = 1'b0;
      end
    end
    shift = 4'(W);
    for (int s = W; s >= 0; s--) begin
      if (ok[s]) shift = 4'(s);
    end
  end

  always_comb begin
    win_sh = '0;
    for (int s = 0; s < W; s++) begin
      if (shift == 4'(s)) begin
        for (int k = 0; k < W - s; k++) win_sh[k] = cur[k + s];
      end
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.last  = in_data_i.in_last;
    if (full_match) begin
      cmd.bytes = rep_q;
      cmd.count = rlen;
      fill_d    = 4'd0;
    end else begin
      for (int k = 0; k < W; k++) cmd.bytes[k] = cur[k];
      cmd.count = in_data_i.in_last ? n : shift;
      fill_d    = in_data_i.in_last ? 4'd0 : n - shift;
    end
  end

  assign push_o.valid = accept_i && (cmd.count != 4'd0);
  assign push_o.cmd   = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      rep_q  <= '0;
      plen_q <= 4'd1;
      rlen_q <= 4'd1;
      fill_q <= 4'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PATTERN_BYTES: begin
          pat_q  <= cfg_data_i;
          fill_q <= 4'd0;
        end
        REG_PATTERN_LENGTH: begin
          plen_q <= cfg_data_i[3:0];
          fill_q <= 4'd0;
        end
        REG_REPLACEMENT_BYTES:  rep_q  <= cfg_data_i;
        REG_REPLACEMENT_LENGTH: rlen_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end else if (accept_i) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) win_q <= win_sh;
  end

endmodule

[design/sfr_queue.sv]
// Small FIFO of output bursts between front and back end.
module sfr_queue
  import sfr_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH_DFLT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sfr_push_t push_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      empty_o,
  output sfr_cmd_t  head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sfr_cmd_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_i.cmd;
  end

endmodule

[design/sfr_back.sv]
// Back end: expands queued bursts into single output beats.
module sfr_back
  import sfr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     head_valid_i,
  input  sfr_cmd_t head_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sfr_out_t out_data_o
);

  localparam int IdxW = $clog2(CMD_BYTES);

  logic [IdxW-1:0] idx_q;
  logic            out_valid_q;
  sfr_out_t        out_q;
  logic            load, tail;

  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign tail  = ({1'b0, idx_q} == 4'(head_i.count - 4'd1));
  assign pop_o = load && tail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= tail ? '0 : idx_q + 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_byte <= head_i.bytes[idx_q];
      out_q.out_last <= head_i.last && tail;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[design/stream_find_replace_unit.sv]
// Top level of the streaming find-and-replace block.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one text byte per
// beat; in_last marks the final byte of a text. Output channel (out_valid_o /
// out_stall_i / out_data_o) gives one edited byte per beat; out_last marks the
// final byte of the edited text. A beat moves when valid is high and stall low.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i (pattern bytes,
// pattern length, replacement bytes, replacement length). Writing the pattern
// or its length drops any pending bytes. Write only while the block is idle.
// Path: an accepted beat's burst is written into the burst queue, then the back end loads
// its first byte into the output register. Throughput, with out_stall_i low: one input
// beat per cycle as long as each beat causes at most one output byte; the back end emits
// one byte per cycle, so a beat that releases k bytes (a replacement or a flush) keeps the
// output busy, and the input stalls once the burst queue (two entries by default) is full.
// Bytes that may still start a match are held back; they show up only once a
// mismatch or the last beat releases them.
// Reset empties the window and the queue and loads pattern length 1,
// replacement length 1 and zero bytes. While out_stall_i is high the output
// beat holds, the queue fills, then in_stall_o rises.
module stream_find_replace_unit
  import sfr_pkg::*;
#(
  parameter int MaxPattern = MAX_PATTERN_DFLT,
  parameter int QueueDepth = QUEUE_DEPTH_DFLT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [CFG_WIDTH-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sfr_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sfr_out_t             out_data_o
);

  sfr_push_t push;
  sfr_cmd_t  head;
  logic      q_full, q_empty, pop, accept;

  // Stall depends only on queue occupancy, never on in_valid_i.
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // Front: window match and burst building, one beat per cycle while the queue is not full.
  sfr_front #(
    .MaxPattern(MaxPattern)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push)
  );

  // Decouples a bursty front from the back, which emits one byte per cycle when not stalled.
  sfr_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .empty_o(q_empty),
    .head_o (head)
  );

  // Back: serializes each burst into the output register.
  sfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(!q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty))
    else $error("queue both full and empty");

  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("back end popped an empty queue");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !q_full)
    else $error("burst pushed into a full queue");

  a_burst_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_empty) |-> (head.count != 4'd0))
    else $error("queued burst has no bytes");

  a_last_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.valid && push.cmd.last && !q_full) |-> push.cmd.count != 4'd0)
    else $error("final beat produced no output");

endmodule
